[rtl/core/wtm_pkg.sv]
`default_nettype none

package wtm_pkg;

  // item actions
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_POP    = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_WR,
    S_BLD_INFO,
    S_BLD_LEAF,
    S_POP_INFO,
    S_POP_LEAF,
    S_NODE_RD,
    S_NODE_WR
  } state_t;

  typedef struct packed {
    act_t               action;
    logic [2:0]         run_id;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic [2:0]         run_id_res;
    logic               empty_res;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/wtm_run_mem.sv]
`default_nettype none

module wtm_run_mem #(
  parameter int RUNS       = 8,
  parameter int RUN_DEPTH  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  clr,
  // element storage
  input  wire logic                                  st_we,
  input  wire logic [$clog2(RUNS*RUN_DEPTH)-1:0]     st_wa,
  input  wire logic [DATA_WIDTH-1:0]                 st_wd,
  input  wire logic [$clog2(RUNS*RUN_DEPTH)-1:0]     st_ra,
  output logic      [DATA_WIDTH-1:0]                 st_rd,
  // per-run length and read position
  input  wire logic                                  info_we,
  input  wire logic [$clog2(RUNS)-1:0]               info_wa,
  input  wire logic [$clog2(RUN_DEPTH+1)-1:0]        info_wlen,
  input  wire logic [$clog2(RUN_DEPTH+1)-1:0]        info_wpos,
  input  wire logic [$clog2(RUNS)-1:0]               info_ra,
  output logic      [$clog2(RUN_DEPTH+1)-1:0]        info_rlen,
  output logic      [$clog2(RUN_DEPTH+1)-1:0]        info_rpos
);

  localparam int ST_DEPTH = RUNS * RUN_DEPTH;
  localparam int LEN_W    = $clog2(RUN_DEPTH + 1);

  logic [DATA_WIDTH-1:0] store_mem [ST_DEPTH];
  logic [2*LEN_W-1:0]    info_mem  [RUNS];
  logic [2*LEN_W-1:0]    info_rd_r;
  logic [RUNS-1:0]       vld_r;
  logic                  rd_vld_r;

  // element storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    st_rd <= store_mem[st_ra];
  end

  // run info storage
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_wa] <= {info_wlen, info_wpos};
    end
    info_rd_r <= info_mem[info_ra];
  end

  // per-run valid bits, a run never written or cleared reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[info_ra];
      if (clr) begin
        vld_r <= '0;
      end else if (info_we) begin
        vld_r[info_wa] <= 1'b1;
      end
    end
  end

  assign info_rlen = rd_vld_r ? info_rd_r[2*LEN_W-1:LEN_W] : '0;
  assign info_rpos = rd_vld_r ? info_rd_r[LEN_W-1:0] : '0;

endmodule

`default_nettype wire

[rtl/core/wtm_node_mem.sv]
`default_nettype none

module wtm_node_mem #(
  parameter int RUNS       = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clr,
  input  wire logic                           we,
  input  wire logic [$clog2(2*RUNS)-1:0]      wa,
  input  wire logic                           w_exh,
  input  wire logic [$clog2(RUNS)-1:0]        w_run,
  input  wire logic [DATA_WIDTH-1:0]          w_val,
  input  wire logic [$clog2(2*RUNS)-1:0]      ra0,
  input  wire logic [$clog2(2*RUNS)-1:0]      ra1,
  output logic                                r0_exh,
  output logic      [$clog2(RUNS)-1:0]        r0_run,
  output logic      [DATA_WIDTH-1:0]          r0_val,
  output logic                                r1_exh,
  output logic      [$clog2(RUNS)-1:0]        r1_run,
  output logic      [DATA_WIDTH-1:0]          r1_val,
  // copy of the root node
  output logic                                root_exh,
  output logic      [$clog2(RUNS)-1:0]        root_run,
  output logic      [DATA_WIDTH-1:0]          root_val
);

  localparam int NODES  = 2 * RUNS;
  localparam int NODE_W = $clog2(NODES);
  localparam int RUN_W  = $clog2(RUNS);
  localparam int ENT_W  = 1 + RUN_W + DATA_WIDTH;
  localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

  logic [ENT_W-1:0]      node_mem [NODES];
  logic [ENT_W-1:0]      rd0_r;
  logic [ENT_W-1:0]      rd1_r;
  logic [NODES-1:0]      vld_r;
  logic                  rd0_vld_r;
  logic                  rd1_vld_r;
  logic                  root_exh_r;
  logic [RUN_W-1:0]      root_run_r;
  logic [DATA_WIDTH-1:0] root_val_r;

  // node storage, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      node_mem[wa] <= {w_exh, w_run, w_val};
    end
    rd0_r <= node_mem[ra0];
    rd1_r <= node_mem[ra1];
  end

  // valid bits and root copy, unwritten nodes read as exhausted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd0_vld_r  <= 1'b0;
      rd1_vld_r  <= 1'b0;
      root_exh_r <= 1'b1;
    end else begin
      rd0_vld_r <= vld_r[ra0];
      rd1_vld_r <= vld_r[ra1];
      if (clr) begin
        vld_r      <= '0;
        root_exh_r <= 1'b1;
      end else if (we) begin
        vld_r[wa] <= 1'b1;
        if (wa == ROOT) begin
          root_exh_r <= w_exh;
        end
      end
    end
  end

  // root payload
  always_ff @(posedge clk) begin
    if (we && (wa == ROOT)) begin
      root_run_r <= w_run;
      root_val_r <= w_val;
    end
  end

  assign r0_exh   = ~rd0_vld_r | rd0_r[ENT_W-1];
  assign r0_run   = rd0_r[ENT_W-2:DATA_WIDTH];
  assign r0_val   = rd0_r[DATA_WIDTH-1:0];
  assign r1_exh   = ~rd1_vld_r | rd1_r[ENT_W-1];
  assign r1_run   = rd1_r[ENT_W-2:DATA_WIDTH];
  assign r1_val   = rd1_r[DATA_WIDTH-1:0];
  assign root_exh = root_exh_r;
  assign root_run = root_run_r;
  assign root_val = root_val_r;

endmodule

`default_nettype wire

[rtl/core/winner_tree_kway_merge.sv]
// Winner-tree merge of RUNS runs of up to RUN_DEPTH signed elements each. Issue an item by
// raising start while busy is low. Build takes the accept, then one run-info read and
// one leaf write per run, then one read and one write of the node memory for each inner
// node. Pop drives its result on out_item with out_valid for exactly one cycle, the cycle
// after it was accepted; the winner comes from a root copy kept in registers. A pop that
// returns a value stays busy to refetch the leaf and replay the tree levels above it,
// each level being one read and one write of the node memory. The receiver cannot stall:
// there is at most one result per pop and it is never held. Run storage and tree nodes
// sit in single-port-write memories with registered reads.
`default_nettype none

module winner_tree_kway_merge #(
  parameter int RUNS       = 8,
  parameter int RUN_DEPTH  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire wtm_pkg::in_item_t in_item,
  output logic                   out_valid,
  output wtm_pkg::out_item_t     out_item
);

  localparam int RUN_W  = $clog2(RUNS);
  localparam int NODE_W = $clog2(2 * RUNS);
  localparam int LEN_W  = $clog2(RUN_DEPTH + 1);
  localparam int ST_AW  = $clog2(RUNS * RUN_DEPTH);
  localparam int EXT_W  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int CMP_W  = RUN_W + 4;
  localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

  wtm_pkg::state_t state_r, state_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic [NODE_W-1:0]     node_r, node_nxt;
  logic                  pop_r, pop_nxt;
  logic                  leaf_exh_r, leaf_exh_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  wtm_pkg::out_item_t    out_item_r, out_item_nxt;

  // memory ports
  logic                  clr;
  logic                  st_we;
  logic [ST_AW-1:0]      st_wa, st_ra;
  logic [DATA_WIDTH-1:0] st_rd;
  logic                  info_we;
  logic [RUN_W-1:0]      info_wa, info_ra;
  logic [LEN_W-1:0]      info_wlen, info_wpos, info_rlen, info_rpos;
  logic                  nd_we;
  logic [NODE_W-1:0]     nd_wa, nd_ra0, nd_ra1;
  logic                  nd_wexh;
  logic [RUN_W-1:0]      nd_wrun;
  logic [DATA_WIDTH-1:0] nd_wval;
  logic                  r0_exh, r1_exh, root_exh;
  logic [RUN_W-1:0]      r0_run, r1_run, root_run;
  logic [DATA_WIDTH-1:0] r0_val, r1_val, root_val;

  // decoded input and helpers
  logic                  accept;
  logic                  rid_ok;
  logic [RUN_W-1:0]      rid;
  logic [EXT_W-1:0]      in_ext;
  logic [EXT_W-1:0]      root_ext;
  logic [ST_AW-1:0]      run_base;
  logic [NODE_W-1:0]     leaf_addr;
  logic [LEN_W-1:0]      pos_adv;
  logic                  pos_live;
  logic                  pick_b;
  logic                  par_exh;
  logic [RUN_W-1:0]      par_run;
  logic [DATA_WIDTH-1:0] par_val;

  assign busy      = (state_r != wtm_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign rid_ok    = (CMP_W'(in_item.run_id) < CMP_W'(RUNS));
  assign rid       = RUN_W'(in_item.run_id);
  assign in_ext    = EXT_W'(in_item.value);
  assign root_ext  = EXT_W'($signed(root_val));
  assign run_base  = ST_AW'(run_r) * ST_AW'(RUN_DEPTH);
  assign leaf_addr = NODE_W'(RUNS) + NODE_W'(run_r);

  // run advance on pop
  assign pos_adv  = (info_rpos < info_rlen) ? LEN_W'(info_rpos + 1'b1) : info_rpos;
  assign pos_live = (pos_adv < info_rlen);

  // one match of the tree: exhausted loses, ties go to the lower run
  always_comb begin
    if (r0_exh) begin
      pick_b = 1'b1;
    end else if (r1_exh) begin
      pick_b = 1'b0;
    end else if ($signed(r1_val) < $signed(r0_val)) begin
      pick_b = 1'b1;
    end else if ($signed(r0_val) < $signed(r1_val)) begin
      pick_b = 1'b0;
    end else begin
      pick_b = (r1_run < r0_run);
    end
    if (r0_exh && r1_exh) begin
      par_exh = 1'b1;
      par_run = r0_run;
      par_val = '0;
    end else begin
      par_exh = 1'b0;
      par_run = pick_b ? r1_run : r0_run;
      par_val = pick_b ? r1_val : r0_val;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wtm_pkg::S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            wtm_pkg::ACT_APPEND: state_nxt = rid_ok ? wtm_pkg::S_APP_WR : wtm_pkg::S_IDLE;
            wtm_pkg::ACT_BUILD:  state_nxt = wtm_pkg::S_BLD_INFO;
            wtm_pkg::ACT_POP:    state_nxt = root_exh ? wtm_pkg::S_IDLE : wtm_pkg::S_POP_INFO;
            default:             state_nxt = wtm_pkg::S_IDLE;
          endcase
        end
      end
      wtm_pkg::S_APP_WR:   state_nxt = wtm_pkg::S_IDLE;
      wtm_pkg::S_BLD_INFO: state_nxt = wtm_pkg::S_BLD_LEAF;
      wtm_pkg::S_BLD_LEAF: begin
        state_nxt = (run_r == RUN_W'(RUNS - 1)) ? wtm_pkg::S_NODE_RD : wtm_pkg::S_BLD_INFO;
      end
      wtm_pkg::S_POP_INFO: state_nxt = wtm_pkg::S_POP_LEAF;
      wtm_pkg::S_POP_LEAF: state_nxt = wtm_pkg::S_NODE_RD;
      wtm_pkg::S_NODE_RD:  state_nxt = wtm_pkg::S_NODE_WR;
      wtm_pkg::S_NODE_WR: begin
        state_nxt = (node_r == ROOT) ? wtm_pkg::S_IDLE : wtm_pkg::S_NODE_RD;
      end
      default:             state_nxt = wtm_pkg::S_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    run_nxt       = run_r;
    node_nxt      = node_r;
    pop_nxt       = pop_r;
    leaf_exh_nxt  = leaf_exh_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    clr       = 1'b0;
    st_we     = 1'b0;
    st_wa     = run_base + ST_AW'(info_rlen);
    st_ra     = run_base;
    info_we   = 1'b0;
    info_wa   = run_r;
    info_wlen = info_rlen;
    info_wpos = info_rpos;
    info_ra   = run_r;
    nd_we     = 1'b0;
    nd_wa     = node_r;
    nd_wexh   = par_exh;
    nd_wrun   = par_run;
    nd_wval   = par_val;
    nd_ra0    = {node_r[NODE_W-2:0], 1'b0};
    nd_ra1    = {node_r[NODE_W-2:0], 1'b1};
    case (state_r)
      wtm_pkg::S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            wtm_pkg::ACT_APPEND: begin
              run_nxt = rid;
              info_ra = rid;
              val_nxt = in_ext[DATA_WIDTH-1:0];
            end
            wtm_pkg::ACT_BUILD: begin
              run_nxt = '0;
              info_ra = '0;
              pop_nxt = 1'b0;
            end
            wtm_pkg::ACT_POP: begin
              out_valid_nxt = 1'b1;
              pop_nxt       = 1'b1;
              run_nxt       = root_run;
              info_ra       = root_run;
              if (root_exh) begin
                out_item_nxt.value_res  = '0;
                out_item_nxt.run_id_res = '0;
                out_item_nxt.empty_res  = 1'b1;
              end else begin
                out_item_nxt.value_res  = root_ext[31:0];
                out_item_nxt.run_id_res = 3'((RUN_W + 3)'(root_run));
                out_item_nxt.empty_res  = 1'b0;
              end
            end
            default: begin
              clr = 1'b1;
            end
          endcase
        end
      end
      wtm_pkg::S_APP_WR: begin
        if (info_rlen < LEN_W'(RUN_DEPTH)) begin
          st_we     = 1'b1;
          info_we   = 1'b1;
          info_wlen = LEN_W'(info_rlen + 1'b1);
        end
      end
      wtm_pkg::S_BLD_INFO: begin
        // rewind the run and fetch its head
        info_we      = 1'b1;
        info_wpos    = '0;
        st_ra        = run_base;
        leaf_exh_nxt = (info_rlen == '0);
      end
      wtm_pkg::S_BLD_LEAF: begin
        nd_we   = 1'b1;
        nd_wa   = leaf_addr;
        nd_wexh = leaf_exh_r;
        nd_wrun = run_r;
        nd_wval = leaf_exh_r ? '0 : st_rd;
        run_nxt = RUN_W'(run_r + 1'b1);
        info_ra = RUN_W'(run_r + 1'b1);
        if (run_r == RUN_W'(RUNS - 1)) begin
          node_nxt = NODE_W'(RUNS - 1);
        end
      end
      wtm_pkg::S_POP_INFO: begin
        // advance the winning run and fetch its next element
        info_we      = 1'b1;
        info_wpos    = pos_adv;
        st_ra        = run_base + (pos_live ? ST_AW'(pos_adv) : '0);
        leaf_exh_nxt = !pos_live;
      end
      wtm_pkg::S_POP_LEAF: begin
        nd_we    = 1'b1;
        nd_wa    = leaf_addr;
        nd_wexh  = leaf_exh_r;
        nd_wrun  = run_r;
        nd_wval  = leaf_exh_r ? '0 : st_rd;
        node_nxt = leaf_addr >> 1;
      end
      wtm_pkg::S_NODE_RD: begin
        // children are read at their fixed addresses above
      end
      wtm_pkg::S_NODE_WR: begin
        nd_we    = 1'b1;
        node_nxt = pop_r ? (node_r >> 1) : NODE_W'(node_r - 1'b1);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wtm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    node_r     <= node_nxt;
    pop_r      <= pop_nxt;
    leaf_exh_r <= leaf_exh_nxt;
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // run storage
  wtm_run_mem #(
    .RUNS       (RUNS),
    .RUN_DEPTH  (RUN_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_run_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .st_we     (st_we),
    .st_wa     (st_wa),
    .st_wd     (val_r),
    .st_ra     (st_ra),
    .st_rd     (st_rd),
    .info_we   (info_we),
    .info_wa   (info_wa),
    .info_wlen (info_wlen),
    .info_wpos (info_wpos),
    .info_ra   (info_ra),
    .info_rlen (info_rlen),
    .info_rpos (info_rpos)
  );

  // tree nodes
  wtm_node_mem #(
    .RUNS       (RUNS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_node_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .we       (nd_we),
    .wa       (nd_wa),
    .w_exh    (nd_wexh),
    .w_run    (nd_wrun),
    .w_val    (nd_wval),
    .ra0      (nd_ra0),
    .ra1      (nd_ra1),
    .r0_exh   (r0_exh),
    .r0_run   (r0_run),
    .r0_val   (r0_val),
    .r1_exh   (r1_exh),
    .r1_run   (r1_run),
    .r1_val   (r1_val),
    .root_exh (root_exh),
    .root_run (root_run),
    .root_val (root_val)
  );

endmodule

`default_nettype wire
